[rtl/lightmap_layer_combiner_macros.svh]
// Assertion macros shared by the lightmap layer combiner RTL.
`ifndef LIGHTMAP_LAYER_COMBINER_MACROS_SVH
`define LIGHTMAP_LAYER_COMBINER_MACROS_SVH

// Check on every rising clock edge outside reset.
`define LMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define LMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/lmc_pkg.sv]
// Types and constants of the lightmap layer combiner.
package lmc_pkg;

  // Field widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SCALE_W  = 12;
  localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;
  localparam int unsigned ACC_W    = 22;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned INT_W    = ACC_W - FRAC_W;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MIX_W    = 10;
  localparam int unsigned NUM_CH   = 3;

  // Stream word widths
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  // Arithmetic constants
  localparam logic [ACC_W-1:0]  ACC_MAX         = {ACC_W{1'b1}};
  localparam logic [MIX_W-1:0]  COLOR_MIX_RESET = 10'd256;
  localparam logic [INT_W-1:0]  BYTE_MAX_INT    = 14'd255;
  localparam logic [BYTE_W-1:0] BYTE_MAX        = 8'hFF;
  localparam int unsigned       DIV_STEPS       = 8;
  localparam int unsigned       MOD_SH          = 20;
  localparam int unsigned       RECIP3          = 683;
  localparam int unsigned       RECIP3_SH       = 11;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DESAT_ENABLE = 1'b0,
    CFG_COLOR_MIX    = 1'b1
  } cfg_reg_e;

  // One packed result word, index in the lowest bits
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] r;
    logic [IDX_W-1:0]  idx;
  } out_word_t;

endpackage

[rtl/lmc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lmc_ram #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lightmap_layer_combiner.sv]
// Top level of the lightmap layer combiner: accumulate, pack and emit lightmap texels.
//
//  channel   | direction | handshake                      | word
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | one layer sample of one texel
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | one packed RGBA texel
//  cfg       | in        | cfg_valid_i / cfg_ready_o      | one register write
//
// One word is taken per clock while the skid register is free; the accumulator store is
// a single RAM with one read and one write port, read a stage ahead of its write, with
// the last write forwarded. A texel is emitted once its last layer has passed stages A,
// B and C, the 8-step pipelined divider for the 255/max rescale, and stages M and P.
// Reset clears only control state; the store needs no clearing pass.
// A stalled output is held in an output register plus a skid register, and the input
// is held off only once both are full.

`include "lightmap_layer_combiner_macros.svh"

module lightmap_layer_combiner #(
  parameter int unsigned MAX_TEXELS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // texel_index, sample_r, sample_g, sample_b, scale_r, scale_g, scale_b, zero pad
  input  logic [lmc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // first_layer
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_index, out_r, out_g, out_b, out_a, zero pad
  output logic [lmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W  = lmc_pkg::IDX_W;
  localparam int unsigned ACC_W  = lmc_pkg::ACC_W;
  localparam int unsigned INT_W  = lmc_pkg::INT_W;
  localparam int unsigned NCH    = lmc_pkg::NUM_CH;
  localparam int unsigned NDIV   = lmc_pkg::DIV_STEPS;
  localparam int unsigned AW     = $clog2(MAX_TEXELS);
  localparam int unsigned PW     = IDX_W + lmc_pkg::MOD_SH;
  localparam bit          WRAP   = MAX_TEXELS < (2 ** IDX_W);
  localparam int unsigned RECIP  = (2 ** lmc_pkg::MOD_SH + MAX_TEXELS - 1) / MAX_TEXELS;
  localparam int unsigned MEM_W  = NCH * ACC_W;

  // ---------------------------------------------------------------- configuration
  logic                             desat_q, desat_d;
  logic [lmc_pkg::MIX_W-1:0]        mix_q, mix_d;

  assign cfg_ready_o = 1'b1;

  // Decode a register write
  always_comb begin
    desat_d = desat_q;
    mix_d   = mix_q;
    if (cfg_valid_i) begin
      case (lmc_pkg::cfg_reg_e'(cfg_index_i))
        lmc_pkg::CFG_DESAT_ENABLE: desat_d = cfg_data_i[0];
        lmc_pkg::CFG_COLOR_MIX:    mix_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desat_q <= 1'b0;
      mix_q   <= lmc_pkg::COLOR_MIX_RESET;
    end else begin
      desat_q <= desat_d;
      mix_q   <= mix_d;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic adv;
  logic accept;
  logic skid_valid_q, skid_valid_d;

  // Whole pipeline advances while the skid register is free
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // ---------------------------------------------------------------- input unpack
  logic [IDX_W-1:0]             in_idx;
  logic [lmc_pkg::SAMPLE_W-1:0] in_smp [NCH];
  logic [lmc_pkg::SCALE_W-1:0]  in_scl [NCH];
  logic [PW-1:0]                in_mod_prod;
  logic [IDX_W-1:0]             in_quo;

  assign in_idx    = s_axis_tdata[9:0];
  assign in_smp[0] = s_axis_tdata[17:10];
  assign in_smp[1] = s_axis_tdata[25:18];
  assign in_smp[2] = s_axis_tdata[33:26];
  assign in_scl[0] = s_axis_tdata[45:34];
  assign in_scl[1] = s_axis_tdata[57:46];
  assign in_scl[2] = s_axis_tdata[69:58];

  // Quotient of index by store depth, by reciprocal
  assign in_mod_prod = PW'(in_idx) * PW'(RECIP);
  assign in_quo      = WRAP ? in_mod_prod[PW-1:lmc_pkg::MOD_SH] : '0;

  // ---------------------------------------------------------------- stage A
  logic                         a_valid_q;
  logic [IDX_W-1:0]             a_idx_q;
  logic [IDX_W-1:0]             a_quo_q;
  logic [lmc_pkg::SAMPLE_W-1:0] a_smp_q [NCH];
  logic [lmc_pkg::SCALE_W-1:0]  a_scl_q [NCH];
  logic                         a_first_q;
  logic                         a_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_idx_q   <= in_idx;
      a_quo_q   <= in_quo;
      a_first_q <= s_axis_tuser;
      a_last_q  <= s_axis_tlast;
      for (int c = 0; c < NCH; c++) begin
        a_smp_q[c] <= in_smp[c];
        a_scl_q[c] <= in_scl[c];
      end
    end
  end

  // Store slot and layer products
  logic [IDX_W-1:0]           a_rem;
  logic [AW-1:0]              a_slot;
  logic [lmc_pkg::PROD_W-1:0] a_prod [NCH];

  assign a_rem  = a_idx_q - IDX_W'(a_quo_q * IDX_W'(MAX_TEXELS));
  assign a_slot = AW'(a_rem);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      a_prod[c] = lmc_pkg::PROD_W'(a_smp_q[c]) * lmc_pkg::PROD_W'(a_scl_q[c]);
    end
  end

  // ---------------------------------------------------------------- stage B: RMW
  logic                       b_valid_q;
  logic [IDX_W-1:0]           b_idx_q;
  logic [AW-1:0]              b_slot_q;
  logic [lmc_pkg::PROD_W-1:0] b_prod_q [NCH];
  logic                       b_first_q;
  logic                       b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_idx_q   <= a_idx_q;
      b_slot_q  <= a_slot;
      b_first_q <= a_first_q;
      b_last_q  <= a_last_q;
      for (int c = 0; c < NCH; c++) begin
        b_prod_q[c] <= a_prod[c];
      end
    end
  end

  logic              ram_re;
  logic              ram_we;
  logic [MEM_W-1:0]  ram_rdata;
  logic [MEM_W-1:0]  ram_wdata;
  logic [MEM_W-1:0]  b_old_word;
  logic [ACC_W-1:0]  b_new [NCH];
  logic [ACC_W:0]    b_sum [NCH];

  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_slot_q;
  logic [MEM_W-1:0]  fwd_data_q;

  assign ram_re = adv && a_valid_q;
  assign ram_we = adv && b_valid_q;

  lmc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_TEXELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (a_slot),
    .rdata_o (ram_rdata)
  );

  // Take the last write when it hit the slot being read
  assign b_old_word = (fwd_valid_q && (fwd_slot_q == b_slot_q)) ? fwd_data_q : ram_rdata;

  // Replace or add with saturation
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      b_sum[c] = (ACC_W + 1)'(b_old_word[c*ACC_W +: ACC_W]) + (ACC_W + 1)'(b_prod_q[c]);
      if (b_first_q) begin
        b_new[c] = ACC_W'(b_prod_q[c]);
      end else if (b_sum[c][ACC_W]) begin
        b_new[c] = lmc_pkg::ACC_MAX;
      end else begin
        b_new[c] = b_sum[c][ACC_W-1:0];
      end
    end
  end

  assign ram_wdata = {b_new[2], b_new[1], b_new[0]};

  // Hold the most recent write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ram_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_slot_q <= b_slot_q;
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------- stage C: max
  logic             c_valid_q;
  logic [IDX_W-1:0] c_idx_q;
  logic [INT_W-1:0] c_int_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q && b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_idx_q <= b_idx_q;
      for (int c = 0; c < NCH; c++) begin
        c_int_q[c] <= b_new[c][ACC_W-1:lmc_pkg::FRAC_W];
      end
    end
  end

  logic [INT_W-1:0]          c_mx_rg;
  logic [INT_W-1:0]          c_mx;
  logic                      c_big;
  logic [INT_W-1:0]          c_div;
  logic [lmc_pkg::BYTE_W-1:0] c_alpha;
  logic [ACC_W-1:0]          c_num [NCH];

  assign c_mx_rg = (c_int_q[0] > c_int_q[1]) ? c_int_q[0] : c_int_q[1];
  assign c_mx    = (c_int_q[2] > c_mx_rg) ? c_int_q[2] : c_mx_rg;
  assign c_big   = c_mx > lmc_pkg::BYTE_MAX_INT;
  // Divide by 255 below the limit so the divider returns the channel unchanged
  assign c_div   = c_big ? c_mx : lmc_pkg::BYTE_MAX_INT;
  assign c_alpha = c_big ? lmc_pkg::BYTE_MAX : c_mx[lmc_pkg::BYTE_W-1:0];

  // Numerator channel * 255
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      c_num[c] = {c_int_q[c], {lmc_pkg::FRAC_W{1'b0}}} - ACC_W'(c_int_q[c]);
    end
  end

  // ---------------------------------------------------------------- divider
  logic [NDIV:0]              dv_valid_q;
  logic [IDX_W-1:0]           dv_idx_q [NDIV+1];
  logic [lmc_pkg::BYTE_W-1:0] dv_a_q   [NDIV+1];
  logic [INT_W-1:0]           dv_d_q   [NDIV+1];
  logic [ACC_W-1:0]           dv_rem_q [NDIV+1][NCH];
  logic [lmc_pkg::BYTE_W-1:0] dv_quo_q [NDIV+1][NCH];

  logic [ACC_W-1:0]           st_dsh [NDIV];
  logic                       st_ge  [NDIV][NCH];
  logic [ACC_W-1:0]           st_rem [NDIV][NCH];

  // One quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      st_dsh[k] = ACC_W'(dv_d_q[k]) << (NDIV - 1 - k);
      for (int c = 0; c < NCH; c++) begin
        st_ge[k][c]  = dv_rem_q[k][c] >= st_dsh[k];
        st_rem[k][c] = st_ge[k][c] ? (dv_rem_q[k][c] - st_dsh[k]) : dv_rem_q[k][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= '0;
    end else if (adv) begin
      dv_valid_q <= {dv_valid_q[NDIV-1:0], c_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_idx_q[0] <= c_idx_q;
      dv_a_q[0]   <= c_alpha;
      dv_d_q[0]   <= c_div;
      for (int c = 0; c < NCH; c++) begin
        dv_rem_q[0][c] <= c_num[c];
        dv_quo_q[0][c] <= '0;
      end
      for (int k = 0; k < NDIV; k++) begin
        dv_idx_q[k+1] <= dv_idx_q[k];
        dv_a_q[k+1]   <= dv_a_q[k];
        dv_d_q[k+1]   <= dv_d_q[k];
        for (int c = 0; c < NCH; c++) begin
          dv_rem_q[k+1][c] <= st_rem[k][c];
          dv_quo_q[k+1][c] <= {dv_quo_q[k][c][lmc_pkg::BYTE_W-2:0], st_ge[k][c]};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage M: mean
  logic [9:0]                  m_sum;
  logic [19:0]                 m_mean_prod;
  logic                        m_valid_q;
  logic [IDX_W-1:0]            m_idx_q;
  logic [lmc_pkg::BYTE_W-1:0]  m_a_q;
  logic [lmc_pkg::BYTE_W-1:0]  m_mean_q;
  logic [lmc_pkg::BYTE_W-1:0]  m_ch_q [NCH];

  // Sum / 3 by reciprocal, exact for sums up to 765
  assign m_sum = 10'(dv_quo_q[NDIV][0]) + 10'(dv_quo_q[NDIV][1]) + 10'(dv_quo_q[NDIV][2]);
  assign m_mean_prod = 20'(m_sum) * 20'(lmc_pkg::RECIP3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= dv_valid_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_idx_q  <= dv_idx_q[NDIV];
      m_a_q    <= dv_a_q[NDIV];
      m_mean_q <= m_mean_prod[lmc_pkg::RECIP3_SH +: lmc_pkg::BYTE_W];
      for (int c = 0; c < NCH; c++) begin
        m_ch_q[c] <= dv_quo_q[NDIV][c];
      end
    end
  end

  // ---------------------------------------------------------------- stage P: mix
  logic signed [8:0]           m_dev [NCH];
  logic signed [10:0]          m_mix;
  logic                        p_valid_q;
  logic [IDX_W-1:0]            p_idx_q;
  logic [lmc_pkg::BYTE_W-1:0]  p_a_q;
  logic [lmc_pkg::BYTE_W-1:0]  p_mean_q;
  logic [lmc_pkg::BYTE_W-1:0]  p_ch_q [NCH];
  logic signed [19:0]          p_dev_q [NCH];

  assign m_mix = $signed({1'b0, mix_q});

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      m_dev[c] = $signed({1'b0, m_ch_q[c]}) - $signed({1'b0, m_mean_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_idx_q  <= m_idx_q;
      p_a_q    <= m_a_q;
      p_mean_q <= m_mean_q;
      for (int c = 0; c < NCH; c++) begin
        p_ch_q[c]  <= m_ch_q[c];
        p_dev_q[c] <= 20'(m_dev[c]) * 20'(m_mix);
      end
    end
  end

  // Blend toward the mean, truncate and clamp to a byte; pass the channel through when desat is off
  logic signed [20:0]          o_sum   [NCH];
  logic [12:0]                 o_int   [NCH];
  logic [lmc_pkg::BYTE_W-1:0]  o_blend [NCH];
  logic [lmc_pkg::BYTE_W-1:0]  o_ch    [NCH];
  lmc_pkg::out_word_t          o_word;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      o_sum[c] = $signed({5'b0, p_mean_q, 8'b0}) + 21'(p_dev_q[c]);
      o_int[c] = o_sum[c][20:8];
      if (o_sum[c][20]) begin
        o_blend[c] = '0;
      end else if (o_int[c] > 13'd255) begin
        o_blend[c] = lmc_pkg::BYTE_MAX;
      end else begin
        o_blend[c] = o_int[c][lmc_pkg::BYTE_W-1:0];
      end
      o_ch[c] = desat_q ? o_blend[c] : p_ch_q[c];
    end
  end

  assign o_word.idx = p_idx_q;
  assign o_word.r   = o_ch[0];
  assign o_word.g   = o_ch[1];
  assign o_word.b   = o_ch[2];
  assign o_word.a   = p_a_q;

  // ---------------------------------------------------------------- output + skid
  lmc_pkg::out_word_t out_q, out_d;
  lmc_pkg::out_word_t skid_q, skid_d;
  logic               out_valid_q, out_valid_d;

  // Fill the output register first, park a word in skid when it is blocked
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || m_axis_tready) begin
      out_d       = o_word;
      out_valid_d = p_valid_q;
    end else if (p_valid_q) begin
      skid_d       = o_word;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lmc_pkg::OUT_TDATA_W - $bits(lmc_pkg::out_word_t)){1'b0}}, out_q};

  // ---------------------------------------------------------------- assertions
  `LMC_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid word held with empty output register")
  `LMC_ASSERT(a_fwd_tracks_write, ram_we |=> fwd_valid_q && (fwd_slot_q == $past(b_slot_q)), "forward register lost the last store write")
  `LMC_ASSERT(a_div_remainder, dv_valid_q[NDIV] |-> (dv_rem_q[NDIV][0] < ACC_W'(dv_d_q[NDIV])) && (dv_rem_q[NDIV][1] < ACC_W'(dv_d_q[NDIV])) && (dv_rem_q[NDIV][2] < ACC_W'(dv_d_q[NDIV])), "divider remainder not below divisor")
  `LMC_ASSERT(a_alpha_tops, m_valid_q |-> (m_a_q >= m_ch_q[0]) && (m_a_q >= m_ch_q[1]) && (m_a_q >= m_ch_q[2]), "alpha below a rescaled channel")
  `LMC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid && s_axis_tready, "output valid or input held off after reset")

endmodule
